// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ----- rtl/htfc_pkg.sv -----
// Types, constants and the CRC-8 function of the humidity/temperature frame checker.
package htfc_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } rx_word_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic        [13:0] humidity_centi;
        logic        [1:0]  status;
    } meas_word_t;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TEMP_BAD = 2'd1;
    localparam logic [1:0] STATUS_HUM_BAD  = 2'd2;

    localparam logic [2:0] POS_TEMP_HIGH = 3'd0;
    localparam logic [2:0] POS_TEMP_LOW  = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC  = 3'd2;
    localparam logic [2:0] POS_HUM_HIGH  = 3'd3;
    localparam logic [2:0] POS_HUM_LOW   = 3'd4;
    localparam logic [2:0] POS_HUM_CRC   = 3'd5;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam logic [14:0] SCALE_TEMP  = 15'd17500;
    localparam logic [14:0] SCALE_HUM   = 15'd10000;
    localparam logic [16:0] FULL_SCALE  = 17'd65535;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;

    localparam logic signed [14:0] TEMP_MIN = -15'sd4500;
    localparam logic signed [14:0] TEMP_MAX = 15'sd13000;
    localparam logic [13:0]        HUM_MAX  = 14'd10000;

    // One byte of CRC-8, MSB first, no reflection.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- rtl/humidity_temp_frame_checker_core.sv -----
// Top level of the humidity/temperature reply checker with CRC-8 checks and scaling.
//
//   Channel | Direction | Word        | Carries
//   rx      | in        | rx_word_t   | one reply byte and its frame start flag
//   meas    | out       | meas_word_t | held temperature, held humidity, status
//
// An accepted byte is held in the input register. The sixth byte of a reply then
// goes from that register through the CRC step and the conversion multiplier, and
// its word is written to the output register once the output is free. One byte is
// accepted every cycle; input stalls only when a sixth byte meets a full output
// register that is not being read. Reset zeroes the frame position and the held
// values and presets the CRC to all ones.
module humidity_temp_frame_checker_core
    import htfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  rx_word_t   rx_data,
    output logic       meas_valid,
    input  logic       meas_ready,
    output meas_word_t meas_data
);

    logic               s1_valid_reg;
    rx_word_t           s1_data_reg;
    logic [2:0]         pos_reg;
    logic [7:0]         crc_reg;
    logic [7:0]         word_high_reg;
    logic [15:0]        raw_reg;
    logic               temp_good_reg;
    logic signed [14:0] held_temp_reg;
    logic [13:0]        held_hum_reg;
    logic               meas_valid_reg;
    meas_word_t         meas_data_reg;

    logic [2:0]         pos;
    logic               last_byte;
    logic               out_free;
    logic               s1_fire;
    logic [7:0]         crc_base;
    logic [7:0]         crc_step;
    logic signed [14:0] conv_temp;
    logic [13:0]        conv_hum;
    logic               hum_good;
    meas_word_t         meas_next;

    htfc_convert u_convert
    (
        .raw               (raw_reg),
        .humidity_mode     (last_byte),
        .temperature_centi (conv_temp),
        .humidity_centi    (conv_hum)
    );

    always_comb
    begin
        if (s1_data_reg.frame_start || pos_reg > POS_HUM_CRC)
            pos = POS_TEMP_HIGH;
        else
            pos = pos_reg;
        last_byte = (pos == POS_HUM_CRC);
        out_free  = !meas_valid_reg || meas_ready;
        s1_fire   = s1_valid_reg && (!last_byte || out_free);
        crc_base  = (pos inside {POS_TEMP_HIGH, POS_HUM_HIGH}) ? CRC_INIT : crc_reg;
        crc_step  = crc8_byte(crc_base, s1_data_reg.rx_byte);
        hum_good  = temp_good_reg && (crc_reg == s1_data_reg.rx_byte);

        meas_next.temperature_centi = held_temp_reg;
        meas_next.humidity_centi    = hum_good ? conv_hum : held_hum_reg;
        if (!temp_good_reg)
            meas_next.status = STATUS_TEMP_BAD;
        else if (!hum_good)
            meas_next.status = STATUS_HUM_BAD;
        else
            meas_next.status = STATUS_OK;
    end

    assign rx_ready   = !s1_valid_reg || s1_fire;
    assign meas_valid = meas_valid_reg;
    assign meas_data  = meas_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx_ready)
        begin
            s1_valid_reg <= rx_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_ready && rx_valid)
        begin
            s1_data_reg <= rx_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_TEMP_HIGH;
            crc_reg       <= CRC_INIT;
            word_high_reg <= '0;
            raw_reg       <= '0;
            temp_good_reg <= 1'b0;
            held_temp_reg <= '0;
            held_hum_reg  <= '0;
        end
        else if (s1_fire)
        begin
            pos_reg <= last_byte ? POS_TEMP_HIGH : pos + 3'd1;
            case (pos)
                POS_TEMP_HIGH, POS_HUM_HIGH:
                begin
                    crc_reg       <= crc_step;
                    word_high_reg <= s1_data_reg.rx_byte;
                end
                POS_TEMP_LOW, POS_HUM_LOW:
                begin
                    crc_reg <= crc_step;
                    raw_reg <= {word_high_reg, s1_data_reg.rx_byte};
                end
                POS_TEMP_CRC:
                begin
                    temp_good_reg <= (crc_reg == s1_data_reg.rx_byte);
                    if (crc_reg == s1_data_reg.rx_byte)
                        held_temp_reg <= conv_temp;
                    crc_reg <= CRC_INIT;
                end
                default:
                begin
                    if (hum_good)
                        held_hum_reg <= conv_hum;
                    crc_reg <= CRC_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_valid_reg <= 1'b0;
        end
        else if (s1_fire && last_byte)
        begin
            meas_valid_reg <= 1'b1;
        end
        else if (meas_ready)
        begin
            meas_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && last_byte)
        begin
            meas_data_reg <= meas_next;
        end
    end

endmodule

// ----- rtl/htfc_convert.sv -----
// Scales a raw 16-bit sensor word to hundredths of a degree or of a percent.
module htfc_convert
    import htfc_pkg::*;
(
    input  logic [15:0]        raw,
    input  logic               humidity_mode,
    output logic signed [14:0] temperature_centi,
    output logic [13:0]        humidity_centi
);

    logic [14:0] scale;
    logic [30:0] product;
    logic [14:0] quot_base;
    logic [16:0] remainder;
    logic        carry;
    logic [14:0] quot;

    // Division by 65535: x = q0 * 65536 + lo gives remainder lo + q0 against 65535,
    // which stays below twice the divisor, so one correction step is enough.
    always_comb
    begin
        scale     = humidity_mode ? SCALE_HUM : SCALE_TEMP;
        product   = 31'(raw) * 31'(scale);
        quot_base = product[30:16];
        remainder = 17'(product[15:0]) + 17'(quot_base);
        carry     = (remainder >= FULL_SCALE);
        quot      = quot_base + 15'(carry);
    end

    assign temperature_centi = $signed(quot - TEMP_OFFSET);
    assign humidity_centi    = quot[13:0];

endmodule

// ----- rtl/htfc_checker.sv -----
// Port-level assertions for the frame checker and the bind that attaches them.
`include "assert_macros.svh"

module htfc_checker
    import htfc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       rx_ready,
    input logic       meas_valid,
    input logic       meas_ready,
    input meas_word_t meas_data
);

    logic out_waiting;
    logic status_known;
    logic temp_in_range;

    assign out_waiting   = meas_valid && !meas_ready;
    assign status_known  = meas_data.status inside {STATUS_OK, STATUS_TEMP_BAD, STATUS_HUM_BAD};
    assign temp_in_range = (meas_data.temperature_centi >= TEMP_MIN) &&
                           (meas_data.temperature_centi <= TEMP_MAX);

    // Input stalls only behind a result word that is not being taken.
    `ASSERT_SAME_CYCLE(a_stall_cause, clk, rst_n, !rx_ready, out_waiting)

    `ASSERT_NEXT_CYCLE(a_out_hold, clk, rst_n, out_waiting, meas_valid && $stable(meas_data))

    `ASSERT_SAME_CYCLE(a_status_code, clk, rst_n, meas_valid, status_known)

    `ASSERT_SAME_CYCLE(a_hum_range, clk, rst_n, meas_valid, meas_data.humidity_centi <= HUM_MAX)

    // Held temperature is zero after reset or a scaled reading.
    `ASSERT_SAME_CYCLE(a_temp_range, clk, rst_n, meas_valid, temp_in_range)

endmodule

bind humidity_temp_frame_checker_core htfc_checker u_htfc_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_ready   (rx_ready),
    .meas_valid (meas_valid),
    .meas_ready (meas_ready),
    .meas_data  (meas_data)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// Testbench for the humidity/temperature reply checker with a scoreboard predictor.
module tb;
    import htfc_pkg::*;

    localparam int ITEM_TARGET  = 1700;
    localparam int DRAIN_CYCLES = 8;
    localparam int DRAIN_LIMIT  = 20000;

    class meas_scoreboard;
        meas_word_t         expected_meas[$];
        logic [2:0]         pos;
        logic [7:0]         crc;
        logic [7:0]         hi_byte;
        logic [15:0]        raw_word;
        bit                 temp_ok;
        logic signed [14:0] held_t;
        logic [13:0]        held_h;
        int unsigned        words_checked;
        int unsigned        failures;
        int unsigned        status_count[4];

        function new();
            pos = POS_TEMP_HIGH;
            crc = CRC_INIT;
            hi_byte = '0;
            raw_word = '0;
            temp_ok = 1'b0;
            held_t = '0;
            held_h = '0;
            words_checked = 0;
            failures = 0;
            foreach (status_count[i])
                status_count[i] = 0;
        endfunction

        static function logic [7:0] crc8_next(logic [7:0] c, logic [7:0] d);
            logic [7:0] r;
            logic       fb;
            r = c;
            for (int i = 7; i >= 0; i--)
            begin
                fb = r[7] ^ d[i];
                r = {r[6:0], 1'b0};
                if (fb)
                    r = r ^ CRC_POLY;
            end
            return r;
        endfunction

        function int pending();
            return expected_meas.size();
        endfunction

        function void note_rx(rx_word_t w);
            logic [2:0]  at;
            logic [31:0] scaled;
            meas_word_t  want;
            at = w.frame_start ? POS_TEMP_HIGH : pos;
            if (at > POS_HUM_CRC)
                at = POS_TEMP_HIGH;
            case (at)
                POS_TEMP_HIGH, POS_HUM_HIGH:
                begin
                    crc = crc8_next(CRC_INIT, w.rx_byte);
                    hi_byte = w.rx_byte;
                end
                POS_TEMP_LOW, POS_HUM_LOW:
                begin
                    crc = crc8_next(crc, w.rx_byte);
                    raw_word = {hi_byte, w.rx_byte};
                end
                POS_TEMP_CRC:
                begin
                    temp_ok = (crc == w.rx_byte);
                    if (temp_ok)
                    begin
                        scaled = 32'd17500 * raw_word / 32'd65535;
                        scaled = scaled - 32'd4500;
                        held_t = scaled[14:0];
                    end
                    crc = CRC_INIT;
                end
                default:
                begin
                    if (!temp_ok)
                        want.status = STATUS_TEMP_BAD;
                    else if (crc != w.rx_byte)
                        want.status = STATUS_HUM_BAD;
                    else
                    begin
                        scaled = 32'd10000 * raw_word / 32'd65535;
                        held_h = scaled[13:0];
                        want.status = STATUS_OK;
                    end
                    want.temperature_centi = held_t;
                    want.humidity_centi = held_h;
                    expected_meas.push_back(want);
                    status_count[want.status]++;
                    crc = CRC_INIT;
                end
            endcase
            pos = (at >= POS_HUM_CRC) ? POS_TEMP_HIGH : at + 3'd1;
        endfunction

        function void check_meas(meas_word_t got);
            meas_word_t want;
            if (expected_meas.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("Unexpected measurement word: temp %0d hum %0d status %0d",
                             got.temperature_centi, got.humidity_centi, got.status);
                return;
            end
            want = expected_meas.pop_front();
            words_checked++;
            if (got.temperature_centi !== want.temperature_centi ||
                got.humidity_centi !== want.humidity_centi || got.status !== want.status)
            begin
                failures++;
                if (failures <= 10)
                    $display({"Word %0d differs: expected temp %0d hum %0d status %0d,",
                              " got temp %0d hum %0d status %0d"},
                             words_checked, want.temperature_centi, want.humidity_centi,
                             want.status, got.temperature_centi, got.humidity_centi,
                             got.status);
            end
        endfunction

        function void flag_leftover();
            if (expected_meas.size() > 0)
            begin
                $display("%0d expected measurement words never arrived", expected_meas.size());
                failures += expected_meas.size();
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           rx_valid;
    logic           rx_ready;
    rx_word_t       rx_data;
    logic           meas_valid;
    logic           meas_ready = 1'b0;
    meas_word_t     meas_data;
    meas_scoreboard board;
    int             ready_left = 0;
    int unsigned    sent_bytes = 0;

    humidity_temp_frame_checker_core u_top
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_ready   (rx_ready),
        .rx_data    (rx_data),
        .meas_valid (meas_valid),
        .meas_ready (meas_ready),
        .meas_data  (meas_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_raw();
        logic [15:0] corners[6];
        corners = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF};
        if ($urandom_range(0, 99) < 12)
            return corners[$urandom_range(0, 5)];
        return 16'($urandom);
    endfunction

    always @(negedge clk)
    begin
        if (ready_left > 0)
            ready_left <= ready_left - 1;
        else if (meas_ready)
        begin
            meas_ready <= 1'b0;
            if ($urandom_range(0, 99) < 60)
                ready_left <= $urandom_range(0, 2);
            else if ($urandom_range(0, 99) < 80)
                ready_left <= $urandom_range(3, 8);
            else
                ready_left <= $urandom_range(20, 60);
        end
        else
        begin
            meas_ready <= 1'b1;
            if ($urandom_range(0, 99) < 80)
                ready_left <= $urandom_range(0, 15);
            else
                ready_left <= $urandom_range(60, 300);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && meas_valid && meas_ready)
            board.check_meas(meas_data);
    end

    task automatic send_byte(input rx_word_t w, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_valid <= 1'b1;
        rx_data <= w;
        do @(posedge clk); while (!rx_ready);
        board.note_rx(w);
        sent_bytes++;
    endtask

    task automatic send_reply(input logic [15:0] t_raw, input logic [15:0] h_raw,
                              input bit start, input int nbytes, input bit bad_t,
                              input bit bad_h, input bit steady);
        logic [7:0] b[6];
        logic [7:0] flip_t;
        logic [7:0] flip_h;
        rx_word_t   w;
        flip_t = bad_t ? 8'($urandom_range(1, 255)) : 8'h00;
        flip_h = bad_h ? 8'($urandom_range(1, 255)) : 8'h00;
        b[0] = t_raw[15:8];
        b[1] = t_raw[7:0];
        b[2] = meas_scoreboard::crc8_next(meas_scoreboard::crc8_next(CRC_INIT, b[0]), b[1])
               ^ flip_t;
        b[3] = h_raw[15:8];
        b[4] = h_raw[7:0];
        b[5] = meas_scoreboard::crc8_next(meas_scoreboard::crc8_next(CRC_INIT, b[3]), b[4])
               ^ flip_h;
        for (int i = 0; i < nbytes; i++)
        begin
            w.rx_byte = b[i];
            w.frame_start = (i == 0) && start;
            send_byte(w, steady ? 0 : pick_gap());
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        rx_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int unsigned target;
        int unsigned kind;
        int unsigned n;
        int          wait_cnt;
        bit          resync;
        bit          drained_mid;
        rx_word_t    w;

        board = new();
        rst_n = 1'b0;
        rx_valid = 1'b0;
        rx_data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extreme words, a dropped partial reply, back-to-back replies, both CRC faults.
        send_reply(16'h0000, 16'h0000, 1'b1, 6, 1'b0, 1'b0, 1'b1);
        send_reply(16'hFFFF, 16'hFFFF, 1'b0, 2, 1'b0, 1'b0, 1'b0);
        send_reply(16'hFFFF, 16'hFFFF, 1'b1, 6, 1'b0, 1'b0, 1'b0);
        send_reply(16'h8000, 16'h7FFF, 1'b0, 6, 1'b1, 1'b0, 1'b1);
        send_reply(pick_raw(), pick_raw(), 1'b0, 6, 1'b0, 1'b1, 1'b0);
        wait_drained();

        target = sent_bytes + ITEM_TARGET;
        resync = 1'b0;
        drained_mid = 1'b0;
        while (sent_bytes < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
                send_reply(pick_raw(), pick_raw(), resync || ($urandom_range(0, 1) == 1), 6,
                           1'b0, 1'b0, $urandom_range(0, 3) == 0);
            else if (kind < 80)
                send_reply(pick_raw(), pick_raw(), resync || ($urandom_range(0, 1) == 1), 6,
                           1'b1, $urandom_range(0, 1) == 1, $urandom_range(0, 3) == 0);
            else if (kind < 88)
                send_reply(pick_raw(), pick_raw(), resync || ($urandom_range(0, 1) == 1), 6,
                           1'b0, 1'b1, $urandom_range(0, 3) == 0);
            else if (kind < 94)
                send_reply(pick_raw(), pick_raw(), $urandom_range(0, 1) == 1,
                           $urandom_range(1, 5), 1'b0, 1'b0, 1'b0);
            else
            begin
                n = $urandom_range(1, 7);
                for (int i = 0; i < n; i++)
                begin
                    w.rx_byte = 8'($urandom);
                    w.frame_start = ($urandom_range(0, 3) == 0);
                    send_byte(w, pick_gap());
                end
            end
            resync = (kind >= 88);
            if (!drained_mid && sent_bytes + ITEM_TARGET / 2 >= target)
            begin
                wait_drained();
                drained_mid = 1'b1;
            end
        end

        @(negedge clk);
        rx_valid <= 1'b0;
        wait_cnt = 0;
        while (board.pending() > 0 && wait_cnt < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        board.flag_leftover();

        $display("Sent %0d reply bytes and compared %0d measurement words.",
                 sent_bytes, board.words_checked);
        $display("Status mix: %0d good, %0d bad temperature CRC, %0d bad humidity CRC.",
                 board.status_count[STATUS_OK], board.status_count[STATUS_TEMP_BAD],
                 board.status_count[STATUS_HUM_BAD]);
        if (board.failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Timed out waiting for the run to finish");
        $display("Mismatches found");
        $finish;
    end

endmodule
